@@ hdl/fdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fdt_pkg;

    localparam int PADS = 4;
    localparam int COUNT_W = 8;
    localparam int TARGET_W = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [COUNT_W-1:0] RESET_THRESHOLD = 8'd70;
    localparam logic [2:0] RESET_TRIP = 3'd2;
    localparam logic [2:0] RESET_FILTER = 3'd4;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOUCH_THRESHOLD = 2'd0,
        CFG_TRIP_SHIFT      = 2'd1,
        CFG_FILTER_SHIFT    = 2'd2
    } cfg_index_t;

    typedef enum logic {
        REQ_CALIB = 1'b0,
        REQ_SCAN  = 1'b1
    } req_type_t;

    // pad numbers reported in target
    localparam logic [TARGET_W-1:0] TARGET_NONE = 3'd0;
    localparam logic [TARGET_W-1:0] TARGET_PAD1 = 3'd1;
    localparam logic [TARGET_W-1:0] TARGET_PAD2 = 3'd2;
    localparam logic [TARGET_W-1:0] TARGET_PAD3 = 3'd3;
    localparam logic [TARGET_W-1:0] TARGET_PAD4 = 3'd4;

    typedef logic [PADS-1:0][COUNT_W-1:0] pad_counts_t;

    typedef struct packed {
        logic               req_type;
        logic [COUNT_W-1:0] count_0;
        logic [COUNT_W-1:0] count_1;
        logic [COUNT_W-1:0] count_2;
        logic [COUNT_W-1:0] count_3;
    } in_item_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [2:0]          active_count;
        logic [PADS-1:0]     touch_bits;
        logic [COUNT_W-1:0]  delta_0;
        logic [COUNT_W-1:0]  delta_1;
        logic [COUNT_W-1:0]  delta_2;
        logic [COUNT_W-1:0]  delta_3;
    } out_item_t;

    // what one pad lane reports to the merge stage
    typedef struct packed {
        logic               active;
        logic               touch;
        logic [COUNT_W-1:0] delta;
    } lane_flags_t;

    typedef lane_flags_t [PADS-1:0] lane_flags_array_t;

endpackage

`default_nettype wire

@@ hdl/fdt_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fdt_lane (
    input  wire logic [fdt_pkg::COUNT_W-1:0] count,
    input  wire logic [fdt_pkg::COUNT_W-1:0] baseline,
    input  wire logic [fdt_pkg::COUNT_W-1:0] touch_threshold,
    input  wire logic [2:0]                  trip_shift,
    input  wire logic [2:0]                  filter_shift,
    output fdt_pkg::lane_flags_t             flags,
    output logic [fdt_pkg::COUNT_W-1:0]      baseline_next
);
    import fdt_pkg::*;

    logic [COUNT_W-1:0] trip_point;

    // trip point sits a fraction of the baseline below it
    assign trip_point = baseline - (baseline >> trip_shift);

    assign flags.active = (count < trip_point);
    assign flags.touch  = (count < touch_threshold);
    assign flags.delta  = baseline - count;

    // first-order tracking filter, wraps at 8 bits
    assign baseline_next = baseline - (baseline >> filter_shift) + (count >> filter_shift);

endmodule

`default_nettype wire

@@ hdl/fdt_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fdt_merge (
    input  wire fdt_pkg::lane_flags_array_t flags,
    output fdt_pkg::out_item_t              result
);
    import fdt_pkg::*;

    logic [2:0]          active_count;
    logic [TARGET_W-1:0] single_target;
    logic [TARGET_W-1:0] tree_target;
    logic [PADS-1:0]     touch_bits;

    always_comb
    begin
        active_count  = '0;
        single_target = TARGET_NONE;
        for (int i = 0; i < PADS; i++)
        begin
            touch_bits[i] = flags[i].touch;
            if (flags[i].active)
            begin
                active_count  = active_count + 3'd1;
                single_target = TARGET_W'(i + 1);
            end
        end
    end

    // fixed comparison tree over all deltas, active or not
    always_comb
    begin
        if (flags[1].delta > flags[2].delta)
        begin
            tree_target = (flags[0].delta > flags[1].delta) ? TARGET_PAD1 : TARGET_PAD2;
        end
        else
        begin
            tree_target = (flags[3].delta > flags[2].delta) ? TARGET_PAD4 : TARGET_PAD3;
        end
    end

    always_comb
    begin
        result.active_count = active_count;
        result.touch_bits   = touch_bits;
        result.delta_0      = flags[0].delta;
        result.delta_1      = flags[1].delta;
        result.delta_2      = flags[2].delta;
        result.delta_3      = flags[3].delta;
        priority if (active_count == 3'd0)
        begin
            result.target = TARGET_NONE;
        end
        else if (active_count == 3'd1)
        begin
            result.target = single_target;
        end
        else
        begin
            result.target = tree_target;
        end
    end

endmodule

`default_nettype wire

@@ hdl/fdt_calib.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fdt_calib #(
    parameter int CAL_SAMPLES = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample,
    input  wire fdt_pkg::pad_counts_t counts,
    output logic                      load,
    output fdt_pkg::pad_counts_t      baseline_init
);
    import fdt_pkg::*;

    localparam int SUM_W   = $clog2(255 * CAL_SAMPLES + 1);
    localparam int CNT_W   = $clog2(CAL_SAMPLES);
    localparam int DIV_K   = SUM_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // exact floor division by reciprocal for every sum below 2**SUM_W
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [CNT_W-1:0] LAST_SAMPLE = CNT_W'(CAL_SAMPLES - 1);

    logic [PADS-1:0][SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]           sample_count_reg;
    logic                       load_reg;
    logic [PADS-1:0][PROD_W-1:0] product;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg          <= '0;
            sample_count_reg <= '0;
            load_reg         <= 1'b0;
        end
        else
        begin
            load_reg <= 1'b0;
            if (load_reg)
            begin
                sum_reg <= '0;
            end
            else if (sample)
            begin
                for (int i = 0; i < PADS; i++)
                begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(counts[i]);
                end
                if (sample_count_reg == LAST_SAMPLE)
                begin
                    sample_count_reg <= '0;
                    load_reg         <= 1'b1;
                end
                else
                begin
                    sample_count_reg <= sample_count_reg + 1'b1;
                end
            end
        end
    end

    // one multiplier per pad, driven straight from the final sums
    always_comb
    begin
        for (int i = 0; i < PADS; i++)
        begin
            product[i]       = PROD_W'(sum_reg[i]) * PROD_W'(RECIP);
            baseline_init[i] = product[i][DIV_K +: COUNT_W];
        end
    end

    assign load = load_reg;

endmodule

`default_nettype wire

@@ hdl/four_pad_touch_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none

// four-pad capacitive touch detector: each item carries one oscillator count
// per pad; calibration items (req_type 0) accumulate CAL_SAMPLES counts per pad
// and then load each baseline with the average, producing no result; scan items
// (req_type 1) produce one result with target pad, active count, raw touch bits
// and baseline deltas; inactive pads track their count via a shift-based filter.
// one item is taken per clock unless stalled: four pad lanes and the merge stage
// settle in the accepting cycle and the result is registered. input stalls when the
// skid is full and in the cycle after the last sample of each calibration round,
// where the reciprocal multipliers load the new baselines. a two-entry output
// buffer (register plus skid) lets input flow while a result waits. baselines and
// calibration sums clear at reset; no init pass. configuration registers must be
// written by the user only while the block is idle; the block does not enforce it.
module four_pad_touch_detector #(
    parameter int CAL_SAMPLES = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire fdt_pkg::in_item_t                in_data,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output fdt_pkg::out_item_t                    out_data,
    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [fdt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [fdt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import fdt_pkg::*;

    // configuration registers
    logic [COUNT_W-1:0] touch_threshold_reg;
    logic [2:0]         trip_shift_reg;
    logic [2:0]         filter_shift_reg;

    // per-pad baselines
    pad_counts_t        baseline_reg;

    // lane and merge results
    pad_counts_t        counts;
    pad_counts_t        baseline_next;
    pad_counts_t        baseline_init;
    lane_flags_array_t  flags;
    out_item_t          result;

    // handshake and output buffer
    logic               in_xfer;
    logic               scan_xfer;
    logic               calib_xfer;
    logic               out_xfer;
    logic               calib_load;
    out_item_t          out_reg;
    logic               out_valid_reg;
    out_item_t          skid_reg;
    logic               skid_valid_reg;

    assign counts = {in_data.count_3, in_data.count_2, in_data.count_1, in_data.count_0};

    // stall while the skid entry is full or baselines are loading
    assign in_stall   = skid_valid_reg | calib_load;
    assign in_xfer    = in_valid & ~in_stall;
    assign scan_xfer  = in_xfer & (in_data.req_type == REQ_SCAN);
    assign calib_xfer = in_xfer & (in_data.req_type == REQ_CALIB);
    assign out_xfer   = out_valid_reg & ~out_stall;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_threshold_reg <= RESET_THRESHOLD;
            trip_shift_reg      <= RESET_TRIP;
            filter_shift_reg    <= RESET_FILTER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOUCH_THRESHOLD: touch_threshold_reg <= cfg_wdata;
                CFG_TRIP_SHIFT:      trip_shift_reg      <= cfg_wdata[2:0];
                CFG_FILTER_SHIFT:    filter_shift_reg    <= cfg_wdata[2:0];
                default:             ;
            endcase
        end
    end

    // one lane per pad
    for (genvar g = 0; g < PADS; g++)
    begin : g_lane
        fdt_lane u_lane (
            .count           (counts[g]),
            .baseline        (baseline_reg[g]),
            .touch_threshold (touch_threshold_reg),
            .trip_shift      (trip_shift_reg),
            .filter_shift    (filter_shift_reg),
            .flags           (flags[g]),
            .baseline_next   (baseline_next[g])
        );
    end

    fdt_merge u_merge (
        .flags  (flags),
        .result (result)
    );

    fdt_calib #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_calib (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (calib_xfer),
        .counts        (counts),
        .load          (calib_load),
        .baseline_init (baseline_init)
    );

    // baselines: calibration load, or tracking of pads that did not trip
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
        end
        else if (calib_load)
        begin
            baseline_reg <= baseline_init;
        end
        else if (scan_xfer)
        begin
            for (int i = 0; i < PADS; i++)
            begin
                if (!flags[i].active)
                begin
                    baseline_reg[i] <= baseline_next[i];
                end
            end
        end
    end

    // output register plus skid entry; skid only fills when output is stuck
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (scan_xfer)
        begin
            if (out_valid_reg && !out_xfer)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload side, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (scan_xfer)
        begin
            if (out_valid_reg && !out_xfer)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // skid entry is only ever filled behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    // no item may enter while baselines are being loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        calib_load |-> in_stall)
        else $error("input accepted during baseline load");

    // an accepted scan always leaves a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_xfer |=> out_valid)
        else $error("scan transfer lost its result");

    // target is zero exactly when no pad is active
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.active_count == 3'd0) == (out_data.target == TARGET_NONE)))
        else $error("target inconsistent with active count");

endmodule

`default_nettype wire

@@ tb/sv/touch_detect_checker.sv @@
`timescale 1ns / 1ps

module touch_detect_checker #(
    parameter int CAL_SAMPLES = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire fdt_pkg::in_item_t               in_data,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire fdt_pkg::out_item_t              out_data,
    input  wire logic                            cfg_we,
    input  wire logic [fdt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fdt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                                   fail_count,
    output int                                   outstanding
);

    import fdt_pkg::*;

    // own copy of the block state and registers
    logic [COUNT_W-1:0] baseline [PADS];
    int                 cal_sum [PADS];
    int                 cal_seen;
    logic [COUNT_W-1:0] threshold;
    logic [2:0]         trip_sh;
    logic [2:0]         filt_sh;

    out_item_t expected_results [$];
    out_item_t oldest;
    int        err_total;

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            err_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // advance the state by one item and queue the scan result it gives
    task automatic track_item(input in_item_t item);
        pad_counts_t        cnt;
        logic [COUNT_W-1:0] delta [PADS];
        logic [COUNT_W-1:0] b;
        logic [COUNT_W-1:0] trip;
        int                 active;
        logic [2:0]         target;
        logic [PADS-1:0]    bits;
        out_item_t          res;
        cnt = {item.count_3, item.count_2, item.count_1, item.count_0};
        if (item.req_type == REQ_CALIB) begin
            for (int i = 0; i < PADS; i++)
                cal_sum[i] += cnt[i];
            cal_seen++;
            if (cal_seen >= CAL_SAMPLES) begin
                for (int i = 0; i < PADS; i++) begin
                    baseline[i] = COUNT_W'(cal_sum[i] / CAL_SAMPLES);
                    cal_sum[i] = 0;
                end
                cal_seen = 0;
            end
        end else begin
            active = 0;
            target = TARGET_NONE;
            bits = '0;
            for (int i = 0; i < PADS; i++) begin
                b = baseline[i];
                trip = b - (b >> trip_sh);
                delta[i] = b - cnt[i];
                if (cnt[i] < threshold)
                    bits[i] = 1'b1;
                if (cnt[i] < trip) begin
                    active++;
                    target = TARGET_PAD1 + 3'(i);
                end else begin
                    baseline[i] = b - (b >> filt_sh) + (cnt[i] >> filt_sh);
                end
            end
            // comparison tree when more than one pad is active
            if (active > 1) begin
                if (delta[1] > delta[2])
                    target = (delta[0] > delta[1]) ? TARGET_PAD1 : TARGET_PAD2;
                else
                    target = (delta[3] > delta[2]) ? TARGET_PAD4 : TARGET_PAD3;
            end
            res.target = target;
            res.active_count = 3'(active);
            res.touch_bits = bits;
            res.delta_0 = delta[0];
            res.delta_1 = delta[1];
            res.delta_2 = delta[2];
            res.delta_3 = delta[3];
            expected_results.push_back(res);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < PADS; i++) begin
                baseline[i] = '0;
                cal_sum[i] = 0;
            end
            cal_seen = 0;
            threshold = RESET_THRESHOLD;
            trip_sh = RESET_TRIP;
            filt_sh = RESET_FILTER;
            expected_results.delete();
            err_total = 0;
            fail_count <= 0;
            outstanding <= 0;
        end else begin
            // results are registered, so a result never stems from the item of this edge
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    err_total++;
                    $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("target", oldest.target, out_data.target);
                    check_field("active_count", oldest.active_count, out_data.active_count);
                    check_field("touch_bits", oldest.touch_bits, out_data.touch_bits);
                    check_field("delta_0", oldest.delta_0, out_data.delta_0);
                    check_field("delta_1", oldest.delta_1, out_data.delta_1);
                    check_field("delta_2", oldest.delta_2, out_data.delta_2);
                    check_field("delta_3", oldest.delta_3, out_data.delta_3);
                end
            end
            if (in_valid && !in_stall)
                track_item(in_data);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TOUCH_THRESHOLD: threshold = cfg_wdata;
                    CFG_TRIP_SHIFT:      trip_sh = cfg_wdata[2:0];
                    CFG_FILTER_SHIFT:    filt_sh = cfg_wdata[2:0];
                    default:             ;
                endcase
            end
            fail_count <= err_total;
            outstanding <= expected_results.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import fdt_pkg::*;

    localparam int CAL_SAMPLES = 16;
    // cycles the receiver holds off in the back-pressure phase
    localparam int HOLD_CYCLES = 80;
    // settle time after the last result: registered output plus calibration bubble
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 10;
    // index with no register behind it, writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int fail_count;
    int outstanding;

    // traffic shaping shared by sender and receiver
    bit quiet;
    bit hold_off_req;

    // per-pad resting level used to shape calibration and scan counts
    int pad_level [PADS];

    four_pad_touch_detector #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    touch_detect_checker #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    // receiver: random stalls, a long counted hold-off on request, none while quiet
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else
            begin
                out_stall <= !quiet && ($urandom_range(99) < 23);
            end
        end
    end

    function automatic in_item_t make_item(input req_type_t kind, input pad_counts_t c);
        in_item_t item;
        item.req_type = kind;
        item.count_0 = c[0];
        item.count_1 = c[1];
        item.count_2 = c[2];
        item.count_3 = c[3];
        return item;
    endfunction

    // a count close to the resting level, clamped to the count range
    function automatic logic [COUNT_W-1:0] near_level(input int lvl);
        int v;
        v = lvl + int'($urandom_range(0, 7)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return COUNT_W'(v);
    endfunction

    // offer one item and return at the edge where its transfer happens;
    // valid stays high so a back-to-back item can follow without a bubble
    task automatic push_item(input in_item_t item);
        while (!quiet && ($urandom_range(99) < 23))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // write all registers once the block has nothing left in flight
    task automatic write_config(input logic [7:0] thr, input logic [2:0] trip_sel,
                                input logic [2:0] filt_sel);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // room for the baseline load after a closing calibration sample
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TOUCH_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        // upper data bits are don't-care for the shift registers
        cfg_index <= CFG_TRIP_SHIFT;
        cfg_wdata <= {5'($urandom), trip_sel};
        @(posedge clk);
        cfg_index <= CFG_FILTER_SHIFT;
        cfg_wdata <= {5'($urandom), filt_sel};
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_wdata <= 8'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one setting: fresh calibration round, then mostly well-formed scans
    task automatic run_phase(input logic [7:0] thr, input logic [2:0] trip_sel,
                             input logic [2:0] filt_sel, input int scans, input bit squeeze);
        pad_counts_t cnt;
        int          r;
        write_config(thr, trip_sel, filt_sel);
        for (int p = 0; p < PADS; p++)
            pad_level[p] = $urandom_range(40, 255);
        for (int k = 0; k < CAL_SAMPLES; k++)
        begin
            // an odd scan inside the round must leave the sums alone
            if ($urandom_range(7) == 0)
                push_item(make_item(REQ_SCAN, pad_counts_t'($urandom)));
            for (int p = 0; p < PADS; p++)
                cnt[p] = near_level(pad_level[p]);
            push_item(make_item(REQ_CALIB, cnt));
        end
        // receiver holds off while the sender keeps offering scans
        if (squeeze)
            hold_off_req = 1'b1;
        for (int k = 0; k < scans; k++)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                push_item(make_item(REQ_SCAN, pad_counts_t'($urandom)));
            end
            else if (r < 12)
            begin
                // stray calibration sample, opens or advances a partial round
                push_item(make_item(REQ_CALIB, pad_counts_t'($urandom)));
            end
            else
            begin
                for (int p = 0; p < PADS; p++)
                    if ($urandom_range(2) == 0)
                        cnt[p] = COUNT_W'($urandom_range(0, pad_level[p] / 2));
                    else
                        cnt[p] = near_level(pad_level[p]);
                push_item(make_item(REQ_SCAN, cnt));
            end
        end
    endtask

    initial
    begin
        pad_counts_t cnt;
        quiet = 1'b0;
        hold_off_req = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_TOUCH_THRESHOLD;
        cfg_wdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset register values
        // scans on zero baselines: nothing can trip, baselines follow the counts
        push_item(make_item(REQ_SCAN, {4{8'h00}}));
        push_item(make_item(REQ_SCAN, {4{8'hff}}));
        push_item(make_item(REQ_SCAN, pad_counts_t'($urandom)));
        // calibration round with extreme samples and one scan in the middle
        push_item(make_item(REQ_CALIB, {4{8'hff}}));
        push_item(make_item(REQ_CALIB, {4{8'h00}}));
        for (int k = 0; k < CAL_SAMPLES - 2; k++)
        begin
            if (k == 6)
                push_item(make_item(REQ_SCAN, pad_counts_t'($urandom)));
            for (int p = 0; p < PADS; p++)
                cnt[p] = COUNT_W'(200 + $urandom_range(0, 15));
            push_item(make_item(REQ_CALIB, cnt));
        end
        // right after the round closes: idle pads, one pad, all pads, two pads
        push_item(make_item(REQ_SCAN, {4{8'd200}}));
        push_item(make_item(REQ_SCAN, {8'd200, 8'd20, 8'd200, 8'd200}));
        push_item(make_item(REQ_SCAN, {4{8'h00}}));
        push_item(make_item(REQ_SCAN, {8'd200, 8'd200, 8'd30, 8'd10}));
        // counts above baseline, deltas wrap
        push_item(make_item(REQ_SCAN, {4{8'hff}}));

        // random part over several settings, extremes first
        run_phase(8'd0, 3'd1, 3'd1, 30, 1'b0);
        run_phase(8'd255, 3'd7, 3'd7, 30, 1'b0);
        // zero shifts: no trip point, baseline jumps to the count
        run_phase(8'd128, 3'd0, 3'd0, 30, 1'b1);
        quiet = 1'b1;
        run_phase(8'($urandom), 3'($urandom_range(1, 7)), 3'($urandom_range(1, 7)), 30, 1'b0);
        quiet = 1'b0;
        run_phase(RESET_THRESHOLD, RESET_TRIP, RESET_FILTER, 30, 1'b0);
        for (int n = 0; n < 3; n++)
            run_phase(8'($urandom), 3'($urandom), 3'($urandom), 30, 1'b0);

        // drain, then leave time for anything stray to show up
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ four_pad_touch_detector.f @@
hdl/fdt_pkg.sv
hdl/fdt_lane.sv
hdl/fdt_merge.sv
hdl/fdt_calib.sv
hdl/four_pad_touch_detector.sv
tb/sv/touch_detect_checker.sv
tb/sv/testbench.sv
